[src/routing_big_m_bound_top_defines.svh]
// Assertion macros for the checker of this block.
`ifndef ROUTING_BIG_M_BOUND_TOP_DEFINES_SVH
`define ROUTING_BIG_M_BOUND_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define RBM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define RBM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/rbm_pkg.sv]
package rbm_pkg;

	typedef enum logic [1:0] {
		OP_DURATION = 2'd0,
		OP_PAIR     = 2'd1,
		OP_COST     = 2'd2,
		OP_FINISH   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK          = 2'd0,
		ERR_NO_DURATION = 2'd1,
		ERR_NO_VEHICLE  = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		REG_END_OF_DAY        = 2'd0,
		REG_COST_PER_DISTANCE = 2'd1,
		REG_PER_VEHICLE_MODE  = 2'd2,
		REG_VEHICLE_COUNT     = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		SRC_GCD   = 2'd0,
		SRC_CDIFF = 2'd1,
		SRC_SPAN  = 2'd2
	} src_t;

	typedef enum logic [1:0] {
		FAC_TIME     = 2'd0,
		FAC_DISTANCE = 2'd1,
		FAC_COST     = 2'd2,
		FAC_COUNT    = 2'd3
	} fac_t;

	typedef enum logic [1:0] {
		DST_WIDE = 2'd0,
		DST_DEN  = 2'd1,
		DST_COST = 2'd2
	} dst_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_GCD,
		S_PAIR_MUL,
		S_PAIR_CMP,
		S_MUL_DEN,
		S_MUL_COST,
		S_MUL_SPAN,
		S_MUL_RATE,
		S_MUL_COUNT,
		S_COMBINE,
		S_FIX,
		S_DIVIDE,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [15:0] end_of_day;
		logic [31:0] cost_per_distance;
		logic        per_vehicle_mode;
		logic [7:0]  vehicle_count;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic gcd_step;
		logic pair_mul;
		logic pair_cmp;
		logic mul_step;
		logic mul_fresh;
		src_t mul_src;
		fac_t mul_fac;
		dst_t mul_dst;
		logic combine;
		logic fix;
		logic div_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		op_t  in_op;
		logic dur_zero;
		logic tt_zero;
		logic fin_error;
		logic per_vehicle;
		logic gcd_done;
		logic mul_last;
		logic div_last;
		logic out_busy;
	} status_t;

endpackage

[src/rbm_if.sv]
interface rbm_item_if #(
	parameter int DURATION_BITS = 16,
	parameter int DISTANCE_BITS = 24
);
	logic                     valid;
	logic                     ready;
	logic [1:0]               operation;
	logic [DURATION_BITS-1:0] duration;
	logic [DISTANCE_BITS-1:0] distance;
	logic [15:0]              travel_time;
	logic [31:0]              vehicle_cost;

	modport source (output valid, operation, duration, distance, travel_time, vehicle_cost,
		input ready);
	modport sink (input valid, operation, duration, distance, travel_time, vehicle_cost,
		output ready);
endinterface

interface rbm_result_if #(
	parameter int DURATION_BITS = 16
);
	logic                     valid;
	logic                     ready;
	logic [63:0]              big_m;
	logic [1:0]               error_code;
	logic                     saturated;
	logic [DURATION_BITS-1:0] min_duration_seen;
	logic [DURATION_BITS-1:0] duration_gcd;

	modport source (output valid, big_m, error_code, saturated, min_duration_seen,
		duration_gcd, input ready);
	modport sink (input valid, big_m, error_code, saturated, min_duration_seen,
		duration_gcd, output ready);
endinterface

[src/rbm_regs.sv]
module rbm_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output rbm_pkg::cfg_t      cfg
);
	rbm_pkg::cfg_t     cfg_q;
	rbm_pkg::reg_idx_t idx;
	logic              wr;

	assign idx    = rbm_pkg::reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.end_of_day        <= 16'd1440;
			cfg_q.cost_per_distance <= 32'd65536;
			cfg_q.per_vehicle_mode  <= 1'b0;
			cfg_q.vehicle_count     <= 8'd1;
		end else if (wr) begin
			unique case (idx)
				rbm_pkg::REG_END_OF_DAY:        cfg_q.end_of_day <= pwdata[15:0];
				rbm_pkg::REG_COST_PER_DISTANCE: cfg_q.cost_per_distance <= pwdata;
				rbm_pkg::REG_PER_VEHICLE_MODE:  cfg_q.per_vehicle_mode <= pwdata[0];
				rbm_pkg::REG_VEHICLE_COUNT:     cfg_q.vehicle_count <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			rbm_pkg::REG_END_OF_DAY:        prdata = {16'd0, cfg_q.end_of_day};
			rbm_pkg::REG_COST_PER_DISTANCE: prdata = cfg_q.cost_per_distance;
			rbm_pkg::REG_PER_VEHICLE_MODE:  prdata = {31'd0, cfg_q.per_vehicle_mode};
			rbm_pkg::REG_VEHICLE_COUNT:     prdata = {24'd0, cfg_q.vehicle_count};
			default:                        prdata = 32'd0;
		endcase
	end
endmodule

[src/rbm_ctrl.sv]
module rbm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rbm_pkg::status_t status,
	output rbm_pkg::cmd_t    cmd
);
	rbm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rbm_pkg::S_IDLE: begin
				if (in_valid) begin
					unique case (status.in_op)
						rbm_pkg::OP_DURATION:
							state_d = status.dur_zero ? rbm_pkg::S_IDLE : rbm_pkg::S_GCD;
						rbm_pkg::OP_PAIR:
							state_d = status.tt_zero ? rbm_pkg::S_IDLE : rbm_pkg::S_PAIR_MUL;
						rbm_pkg::OP_COST:
							state_d = rbm_pkg::S_IDLE;
						rbm_pkg::OP_FINISH:
							state_d = status.fin_error ? rbm_pkg::S_EMIT : rbm_pkg::S_MUL_DEN;
						default:
							state_d = rbm_pkg::S_IDLE;
					endcase
				end
			end
			rbm_pkg::S_GCD:      if (status.gcd_done) state_d = rbm_pkg::S_IDLE;
			rbm_pkg::S_PAIR_MUL: state_d = rbm_pkg::S_PAIR_CMP;
			rbm_pkg::S_PAIR_CMP: state_d = rbm_pkg::S_IDLE;
			rbm_pkg::S_MUL_DEN: begin
				if (status.mul_last) begin
					state_d = status.per_vehicle ? rbm_pkg::S_MUL_COST : rbm_pkg::S_MUL_SPAN;
				end
			end
			rbm_pkg::S_MUL_COST: if (status.mul_last) state_d = rbm_pkg::S_MUL_SPAN;
			rbm_pkg::S_MUL_SPAN: if (status.mul_last) state_d = rbm_pkg::S_MUL_RATE;
			rbm_pkg::S_MUL_RATE: begin
				if (status.mul_last) begin
					state_d = status.per_vehicle ? rbm_pkg::S_MUL_COUNT : rbm_pkg::S_COMBINE;
				end
			end
			rbm_pkg::S_MUL_COUNT: if (status.mul_last) state_d = rbm_pkg::S_COMBINE;
			rbm_pkg::S_COMBINE:   state_d = rbm_pkg::S_FIX;
			rbm_pkg::S_FIX:       state_d = rbm_pkg::S_DIVIDE;
			rbm_pkg::S_DIVIDE:    if (status.div_last) state_d = rbm_pkg::S_EMIT;
			rbm_pkg::S_EMIT:      if (!status.out_busy) state_d = rbm_pkg::S_IDLE;
			default:              state_d = rbm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.mul_src   = rbm_pkg::SRC_GCD;
		cmd.mul_fac   = rbm_pkg::FAC_TIME;
		cmd.mul_dst   = rbm_pkg::DST_WIDE;
		in_ready      = 1'b0;
		unique case (state_q)
			rbm_pkg::S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			rbm_pkg::S_GCD:      cmd.gcd_step = 1'b1;
			rbm_pkg::S_PAIR_MUL: cmd.pair_mul = 1'b1;
			rbm_pkg::S_PAIR_CMP: cmd.pair_cmp = 1'b1;
			rbm_pkg::S_MUL_DEN: begin
				cmd.mul_step  = 1'b1;
				cmd.mul_fresh = 1'b1;
				cmd.mul_src   = rbm_pkg::SRC_GCD;
				cmd.mul_fac   = rbm_pkg::FAC_TIME;
				cmd.mul_dst   = rbm_pkg::DST_DEN;
			end
			rbm_pkg::S_MUL_COST: begin
				cmd.mul_step  = 1'b1;
				cmd.mul_fresh = 1'b1;
				cmd.mul_src   = rbm_pkg::SRC_CDIFF;
				cmd.mul_fac   = rbm_pkg::FAC_TIME;
				cmd.mul_dst   = rbm_pkg::DST_COST;
			end
			rbm_pkg::S_MUL_SPAN: begin
				cmd.mul_step  = 1'b1;
				cmd.mul_fresh = 1'b1;
				cmd.mul_src   = rbm_pkg::SRC_SPAN;
				cmd.mul_fac   = rbm_pkg::FAC_DISTANCE;
			end
			rbm_pkg::S_MUL_RATE: begin
				cmd.mul_step = 1'b1;
				cmd.mul_fac  = rbm_pkg::FAC_COST;
			end
			rbm_pkg::S_MUL_COUNT: begin
				cmd.mul_step = 1'b1;
				cmd.mul_fac  = rbm_pkg::FAC_COUNT;
			end
			rbm_pkg::S_COMBINE: cmd.combine  = 1'b1;
			rbm_pkg::S_FIX:     cmd.fix      = 1'b1;
			rbm_pkg::S_DIVIDE:  cmd.div_step = 1'b1;
			rbm_pkg::S_EMIT:    cmd.emit     = !status.out_busy;
			default: ;
		endcase
	end
endmodule

[src/rbm_datapath.sv]
module rbm_datapath #(
	parameter int DURATION_BITS = 16,
	parameter int DISTANCE_BITS = 24,
	parameter int FRACTION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rbm_pkg::cfg_t            cfg,
	input  rbm_pkg::cmd_t            cmd,
	output rbm_pkg::status_t         status,
	input  logic [1:0]               operation,
	input  logic [DURATION_BITS-1:0] duration,
	input  logic [DISTANCE_BITS-1:0] distance,
	input  logic [15:0]              travel_time,
	input  logic [31:0]              vehicle_cost,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic [63:0]              big_m,
	output logic [1:0]               error_code,
	output logic                     saturated,
	output logic [DURATION_BITS-1:0] min_duration_seen,
	output logic [DURATION_BITS-1:0] duration_gcd
);
	localparam int D          = DURATION_BITS;
	localparam int X          = DISTANCE_BITS;
	localparam int SW         = (D > 16) ? D : 16;
	localparam int KW         = $clog2(D + 1);
	localparam int NUM_SHIFT  = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
	localparam int DEN_SHIFT  = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
	localparam logic [39:0] COST_MAX = '1;
	localparam logic [63:0] POS_MAX  = {1'b0, {63{1'b1}}};
	localparam logic [63:0] NEG_MAX  = {1'b1, 63'd0};

	// Accumulated state, cleared after every finish.
	logic [D-1:0]  smallest_q;
	logic [D-1:0]  gcd_q;
	logic          have_dur_q;
	logic [X-1:0]  best_dist_q;
	logic [15:0]   best_time_q;
	logic [39:0]   cost_total_q;
	logic [31:0]   cheapest_q;
	logic          have_veh_q;

	// Working registers.
	logic [D-1:0]  ga_q, gb_q;
	logic [KW-1:0] gk_q;
	logic [X-1:0]  dist_q;
	logic [15:0]   tt_q;
	logic [X+15:0] p_new_q, p_old_q;
	logic [127:0]  w_q;
	logic [31:0]   carry_q;
	logic [1:0]    limb_q;
	logic [63:0]   den_q, costb_q, r_q;
	logic [127:0]  num_q, nq_q;
	logic          borrow_q, rneg_q;
	logic [6:0]    cnt_q;
	logic          out_valid_q;
	logic [63:0]   big_m_q;
	logic [1:0]    err_q;
	logic          sat_q;
	logic [D-1:0]  mind_q, dgcd_q;

	logic          fin_error;
	logic [D-1:0]  ga_d, gb_d, gcd_res;
	logic [KW-1:0] gk_d;
	logic [40:0]   cost_sum;
	logic          neg;
	logic [SW-1:0] span;
	logic [63:0]   cdiff;
	logic [127:0]  src_v;
	logic [31:0]   limb_in, fac_v, carry_in;
	logic [63:0]   prod;
	logic [127:0]  w_next;
	logic [127:0]  cost_ext;
	logic [128:0]  sum;
	logic [127:0]  fixed;
	logic [63:0]   den_d, r_sh;
	logic          r_ge;
	rbm_pkg::err_t err_d;
	logic [63:0]   bigm_d;
	logic          sat_d;

	assign fin_error = !have_dur_q || (cfg.per_vehicle_mode && !have_veh_q);

	assign status.in_op       = rbm_pkg::op_t'(operation);
	assign status.dur_zero    = (duration == '0);
	assign status.tt_zero     = (travel_time == 16'd0);
	assign status.fin_error   = fin_error;
	assign status.per_vehicle = cfg.per_vehicle_mode;
	assign status.gcd_done    = (ga_q == '0) || (gb_q == '0);
	assign status.mul_last    = (limb_q == 2'd3);
	assign status.div_last    = &cnt_q;
	assign status.out_busy    = out_valid_q && !out_ready;

	// One step of the binary GCD.
	always_comb begin
		ga_d    = ga_q;
		gb_d    = gb_q;
		gk_d    = gk_q;
		gcd_res = (ga_q | gb_q) << gk_q;
		case ({ga_q[0], gb_q[0]})
			2'b00: begin
				ga_d = ga_q >> 1;
				gb_d = gb_q >> 1;
				gk_d = gk_q + KW'(1);
			end
			2'b01: ga_d = ga_q >> 1;
			2'b10: gb_d = gb_q >> 1;
			default: begin
				if (ga_q >= gb_q) ga_d = (ga_q - gb_q) >> 1;
				else gb_d = (gb_q - ga_q) >> 1;
			end
		endcase
	end

	assign cost_sum = {1'b0, cost_total_q} + 41'(vehicle_cost);
	assign neg      = SW'(smallest_q) > SW'(cfg.end_of_day);
	assign span     = neg ? SW'(smallest_q) - SW'(cfg.end_of_day)
		: SW'(cfg.end_of_day) - SW'(smallest_q);
	assign cdiff    = 64'(cost_total_q) - 64'(cheapest_q);

	// Shared 32x32 limb multiplier; a product takes four steps, low limb first.
	always_comb begin
		case (cmd.mul_src)
			rbm_pkg::SRC_GCD:   src_v = 128'(gcd_q);
			rbm_pkg::SRC_CDIFF: src_v = 128'(cdiff);
			rbm_pkg::SRC_SPAN:  src_v = 128'(span);
			default:            src_v = '0;
		endcase
		case (cmd.mul_fac)
			rbm_pkg::FAC_TIME:     fac_v = 32'(best_time_q);
			rbm_pkg::FAC_DISTANCE: fac_v = 32'(best_dist_q);
			rbm_pkg::FAC_COST:     fac_v = cfg.cost_per_distance;
			default:               fac_v = 32'(cfg.vehicle_count);
		endcase
	end

	assign limb_in  = cmd.mul_fresh ? src_v[{limb_q, 5'd0} +: 32] : w_q[31:0];
	assign carry_in = (limb_q == 2'd0) ? 32'd0 : carry_q;
	assign prod     = limb_in * fac_v + 64'(carry_in);
	assign w_next   = {prod[31:0], w_q[127:32]};

	assign cost_ext = cfg.per_vehicle_mode ? 128'(costb_q) : '0;
	assign sum      = neg ? {1'b0, w_q} - {1'b0, cost_ext} : {1'b0, w_q} + {1'b0, cost_ext};
	assign fixed    = borrow_q ? (~num_q + 128'd1) : num_q;

	assign den_d = den_q << DEN_SHIFT;
	assign r_sh  = {r_q[62:0], nq_q[127]};
	assign r_ge  = r_sh >= den_d;

	// Result assembly; nq_q holds the quotient once the divide is through.
	always_comb begin
		err_d  = rbm_pkg::ERR_OK;
		bigm_d = 64'd0;
		sat_d  = 1'b0;
		if (!have_dur_q) begin
			err_d = rbm_pkg::ERR_NO_DURATION;
		end else if (fin_error) begin
			err_d = rbm_pkg::ERR_NO_VEHICLE;
		end else if (!rneg_q) begin
			if ((nq_q[127:64] != '0) || nq_q[63]) begin
				bigm_d = POS_MAX;
				sat_d  = 1'b1;
			end else begin
				bigm_d = nq_q[63:0];
			end
		end else begin
			if ((nq_q[127:64] != '0) || (nq_q[63:0] > NEG_MAX)) begin
				bigm_d = NEG_MAX;
				sat_d  = 1'b1;
			end else begin
				bigm_d = 64'd0 - nq_q[63:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smallest_q   <= '1;
			gcd_q        <= '0;
			have_dur_q   <= 1'b0;
			best_dist_q  <= '0;
			best_time_q  <= 16'd1;
			cost_total_q <= '0;
			cheapest_q   <= '1;
			have_veh_q   <= 1'b0;
		end else if (cmd.emit) begin
			smallest_q   <= '1;
			gcd_q        <= '0;
			have_dur_q   <= 1'b0;
			best_dist_q  <= '0;
			best_time_q  <= 16'd1;
			cost_total_q <= '0;
			cheapest_q   <= '1;
			have_veh_q   <= 1'b0;
		end else begin
			if (cmd.accept) begin
				case (rbm_pkg::op_t'(operation))
					rbm_pkg::OP_DURATION: begin
						if (duration != '0) begin
							if (!have_dur_q || duration < smallest_q) smallest_q <= duration;
							have_dur_q <= 1'b1;
						end
					end
					rbm_pkg::OP_COST: begin
						cost_total_q <= cost_sum[40] ? COST_MAX : cost_sum[39:0];
						if (!have_veh_q || vehicle_cost < cheapest_q) cheapest_q <= vehicle_cost;
						have_veh_q <= 1'b1;
					end
					default: ;
				endcase
			end
			if (cmd.gcd_step && status.gcd_done) gcd_q <= gcd_res;
			if (cmd.pair_cmp && (p_new_q > p_old_q)) begin
				best_dist_q <= dist_q;
				best_time_q <= tt_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limb_q      <= 2'd0;
			cnt_q       <= 7'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.mul_step) limb_q <= limb_q + 2'd1;
			if (cmd.fix) cnt_q <= 7'd0;
			else if (cmd.div_step) cnt_q <= cnt_q + 7'd1;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ga_q   <= gcd_q;
			gb_q   <= duration;
			gk_q   <= '0;
			dist_q <= distance;
			tt_q   <= travel_time;
		end else if (cmd.gcd_step) begin
			ga_q <= ga_d;
			gb_q <= gb_d;
			gk_q <= gk_d;
		end
		if (cmd.pair_mul) begin
			p_new_q <= (X + 16)'(dist_q) * (X + 16)'(best_time_q);
			p_old_q <= (X + 16)'(best_dist_q) * (X + 16)'(tt_q);
		end
		if (cmd.mul_step) begin
			w_q     <= w_next;
			carry_q <= prod[63:32];
			if (limb_q == 2'd3 && cmd.mul_dst == rbm_pkg::DST_DEN) den_q <= w_next[63:0];
			if (limb_q == 2'd3 && cmd.mul_dst == rbm_pkg::DST_COST) costb_q <= w_next[63:0];
		end
		if (cmd.combine) begin
			num_q    <= sum[127:0];
			borrow_q <= neg && sum[128];
			rneg_q   <= neg;
		end
		if (cmd.fix) begin
			nq_q   <= fixed << NUM_SHIFT;
			r_q    <= 64'd0;
			rneg_q <= rneg_q && !borrow_q;
		end else if (cmd.div_step) begin
			r_q  <= r_ge ? r_sh - den_d : r_sh;
			nq_q <= {nq_q[126:0], r_ge};
		end
		if (cmd.emit) begin
			big_m_q <= bigm_d;
			err_q   <= err_d;
			sat_q   <= sat_d;
			mind_q  <= have_dur_q ? smallest_q : '0;
			dgcd_q  <= have_dur_q ? gcd_q : '0;
		end
	end

	assign out_valid         = out_valid_q;
	assign big_m             = big_m_q;
	assign error_code        = err_q;
	assign saturated         = sat_q;
	assign min_duration_seen = mind_q;
	assign duration_gcd      = dgcd_q;
endmodule

[src/routing_big_m_bound_top.sv]
// Big-M bound engine. Items arrive one at a time on the item channel and the
// block takes a new one whenever its sequencer is idle. A duration item runs
// the binary GCD loop; a distance/time pair forms its products, then compares
// them; a vehicle cost is folded in as it is taken. A finish item runs the
// fraction through one shared 32x32 limb multiplier, three or five products
// in turn, then a restoring divider at one quotient bit a cycle over 128
// quotient bits, or goes straight to the output when it ends in an error.
// The result sits in an output register, so further items are taken while it
// waits; a second finish holds until the first result has been taken.
// Registers are written over the APB port at 4*index and must only change
// while idle.
module routing_big_m_bound_top #(
	parameter int DURATION_BITS = 16,
	parameter int DISTANCE_BITS = 24,
	parameter int FRACTION_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	rbm_item_if.sink      item,
	rbm_result_if.source  result,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	rbm_pkg::cfg_t    cfg;
	rbm_pkg::cmd_t    cmd;
	rbm_pkg::status_t status;

	rbm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.status   (status),
		.cmd      (cmd)
	);

	rbm_datapath #(
		.DURATION_BITS (DURATION_BITS),
		.DISTANCE_BITS (DISTANCE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.cmd               (cmd),
		.status            (status),
		.operation         (item.operation),
		.duration          (item.duration),
		.distance          (item.distance),
		.travel_time       (item.travel_time),
		.vehicle_cost      (item.vehicle_cost),
		.out_ready         (result.ready),
		.out_valid         (result.valid),
		.big_m             (result.big_m),
		.error_code        (result.error_code),
		.saturated         (result.saturated),
		.min_duration_seen (result.min_duration_seen),
		.duration_gcd      (result.duration_gcd)
	);
endmodule

[src/rbm_checker.sv]
`include "routing_big_m_bound_top_defines.svh"

module rbm_checker #(
	parameter int DURATION_BITS = 16
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     result_valid,
	input logic                     result_ready,
	input logic [63:0]              big_m,
	input logic [1:0]               error_code,
	input logic                     saturated,
	input logic [DURATION_BITS-1:0] min_duration_seen,
	input logic [DURATION_BITS-1:0] duration_gcd
);
	localparam logic [63:0] POS_MAX = {1'b0, {63{1'b1}}};
	localparam logic [63:0] NEG_MAX = {1'b1, 63'd0};

	// A waiting beat must not change before it is taken.
	`RBM_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(big_m) && $stable(error_code), "result beat changed while stalled")

	// Any error suppresses the bound.
	`RBM_ASSERT_NOW(a_error_no_bound, result_valid && (error_code != 2'd0), (big_m == 64'd0) && !saturated, "bound reported with an error")

	// Without a duration there is nothing to report.
	`RBM_ASSERT_NOW(a_no_duration, result_valid && (error_code == 2'd1), (min_duration_seen == '0) && (duration_gcd == '0), "duration stats reported without durations")

	// A clamped bound sits on one of the two limits.
	`RBM_ASSERT_NOW(a_sat_limit, result_valid && saturated, (big_m == POS_MAX) || (big_m == NEG_MAX), "saturated bound off the limits")

	// The GCD divides the minimum, so it is nonzero and no larger.
	`RBM_ASSERT_NOW(a_gcd_le_min, result_valid && (error_code != 2'd1), (duration_gcd != '0) && (duration_gcd <= min_duration_seen), "gcd exceeds smallest duration")
endmodule

bind routing_big_m_bound_top rbm_checker #(
	.DURATION_BITS (DURATION_BITS)
) u_rbm_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.result_valid      (result.valid),
	.result_ready      (result.ready),
	.big_m             (result.big_m),
	.error_code        (result.error_code),
	.saturated         (result.saturated),
	.min_duration_seen (result.min_duration_seen),
	.duration_gcd      (result.duration_gcd)
);

[verif/routing_big_m_bound_top_test.sv]
module routing_big_m_bound_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		rbm_pkg::op_t op;
		logic [15:0]  dur;
		logic [23:0]  distance;
		logic [15:0]  tt;
		logic [31:0]  vc;
	} route_item_t;

	typedef struct {
		logic [63:0]   big_m;
		rbm_pkg::err_t err;
		logic          sat;
		logic [15:0]   mind;
		logic [15:0]   gcd;
	} bound_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	rbm_item_if   item_bus ();
	rbm_result_if res_bus ();

	routing_big_m_bound_top u_dut (
		.clk(clk), .arst_n(arst_n), .item(item_bus), .result(res_bus),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	route_item_t pending_items[$];
	bound_t      expected_bounds[$];
	int          error_count = 0;
	int          cycle_count = 0;
	int          send_gap = 0, take_gap = 0;
	bit          no_idle = 1'b0;
	logic        long_hold = 1'b0;
	route_item_t drv_item;

	// Configuration as the block should hold it.
	logic [15:0] cfg_day_end = 16'd1440;
	logic [31:0] cfg_rate = 32'd65536;
	logic        cfg_per_vehicle = 1'b0;
	logic [7:0]  cfg_fleet = 8'd1;

	// Accumulated bound state.
	logic [15:0] min_dur;
	logic [15:0] dur_gcd;
	logic        seen_dur;
	logic [23:0] top_dist;
	logic [15:0] top_time;
	logic [39:0] cost_sum;
	logic [31:0] cost_min;
	logic        seen_vehicle;

	function automatic void clear_bound_state();
		min_dur = '1;
		dur_gcd = '0;
		seen_dur = 1'b0;
		top_dist = '0;
		top_time = 16'd1;
		cost_sum = '0;
		cost_min = '1;
		seen_vehicle = 1'b0;
	endfunction

	function automatic logic [15:0] euclid(logic [15:0] a, logic [15:0] b);
		logic [15:0] r;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	function automatic bit fold_item(route_item_t it, output bound_t res);
		logic [16:0]  span;
		logic [127:0] prod, fixed_part, num, quo;
		logic [63:0]  den;
		logic [40:0]  sum;
		bit           neg, res_neg;
		res = '{big_m: '0, err: rbm_pkg::ERR_OK, sat: 1'b0, mind: '0, gcd: '0};
		case (it.op)
			rbm_pkg::OP_DURATION: begin
				if (it.dur != 0) begin
					if (!seen_dur || it.dur < min_dur)
						min_dur = it.dur;
					dur_gcd = euclid(dur_gcd, it.dur);
					seen_dur = 1'b1;
				end
				return 0;
			end
			rbm_pkg::OP_PAIR: begin
				if (it.tt != 0 &&
					64'(it.distance) * 64'(top_time) > 64'(top_dist) * 64'(it.tt)) begin
					top_dist = it.distance;
					top_time = it.tt;
				end
				return 0;
			end
			rbm_pkg::OP_COST: begin
				sum = 41'(cost_sum) + 41'(it.vc);
				cost_sum = sum[40] ? '1 : sum[39:0];
				if (!seen_vehicle || it.vc < cost_min)
					cost_min = it.vc;
				seen_vehicle = 1'b1;
				return 0;
			end
			default: begin
			end
		endcase
		if (!seen_dur) begin
			res.err = rbm_pkg::ERR_NO_DURATION;
		end else begin
			res.mind = min_dur;
			res.gcd = dur_gcd;
			if (cfg_per_vehicle && !seen_vehicle) begin
				res.err = rbm_pkg::ERR_NO_VEHICLE;
			end else begin
				neg = min_dur > cfg_day_end;
				span = neg ? 17'(min_dur) - 17'(cfg_day_end) : 17'(cfg_day_end) - 17'(min_dur);
				prod = 128'(span) * 128'(top_dist) * 128'(cfg_rate);
				res_neg = neg;
				if (cfg_per_vehicle) begin
					prod = prod * 128'(cfg_fleet);
					fixed_part = 128'(cost_sum - 40'(cost_min)) * 128'(top_time);
					if (!neg)
						num = prod + fixed_part;
					else if (prod >= fixed_part)
						num = prod - fixed_part;
					else begin
						num = fixed_part - prod;
						res_neg = 1'b0;
					end
				end else begin
					num = prod;
				end
				den = 64'(top_time) * 64'(dur_gcd);
				quo = num / 128'(den);
				if (!res_neg) begin
					if (quo > 128'h7fff_ffff_ffff_ffff) begin
						res.big_m = 64'h7fff_ffff_ffff_ffff;
						res.sat = 1'b1;
					end else
						res.big_m = quo[63:0];
				end else begin
					if (quo > 128'h8000_0000_0000_0000) begin
						res.big_m = 64'h8000_0000_0000_0000;
						res.sat = 1'b1;
					end else
						res.big_m = -quo[63:0];
				end
			end
		end
		clear_bound_state();
		return 1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic report(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch on %s: got %h, expected %h", field, got, want);
		error_count++;
	endtask

	// Item driver.
	initial begin
		item_bus.valid = 1'b0;
		item_bus.operation = '0;
		item_bus.duration = '0;
		item_bus.distance = '0;
		item_bus.travel_time = '0;
		item_bus.vehicle_cost = '0;
		res_bus.ready = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_bus.valid <= 1'b0;
			send_gap <= 0;
		end else if (!item_bus.valid || item_bus.ready) begin
			if (send_gap != 0 || pending_items.size() == 0) begin
				item_bus.valid <= 1'b0;
				if (send_gap != 0)
					send_gap <= send_gap - 1;
			end else begin
				drv_item = pending_items.pop_front();
				item_bus.valid <= 1'b1;
				item_bus.operation <= drv_item.op;
				item_bus.duration <= drv_item.dur;
				item_bus.distance <= drv_item.distance;
				item_bus.travel_time <= drv_item.tt;
				item_bus.vehicle_cost <= drv_item.vc;
				send_gap <= pick_gap();
			end
		end
	end

	// Result receiver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
			take_gap <= 0;
		end else if (long_hold) begin
			res_bus.ready <= 1'b0;
		end else if (take_gap != 0) begin
			res_bus.ready <= 1'b0;
			take_gap <= take_gap - 1;
		end else begin
			res_bus.ready <= 1'b1;
			if ($urandom_range(0, 9) < 4)
				take_gap <= pick_gap();
		end
	end

	// Monitor: checks each result beat, then predicts from each item beat.
	always @(posedge clk) begin
		route_item_t seen;
		bound_t      got, want;
		if (arst_n) begin
			if (res_bus.valid && res_bus.ready) begin
				got.big_m = res_bus.big_m;
				got.err = rbm_pkg::err_t'(res_bus.error_code);
				got.sat = res_bus.saturated;
				got.mind = res_bus.min_duration_seen;
				got.gcd = res_bus.duration_gcd;
				if (expected_bounds.size() == 0) begin
					report("unexpected result", got.big_m, '0);
				end else begin
					want = expected_bounds.pop_front();
					if (got.big_m !== want.big_m)
						report("big_m", got.big_m, want.big_m);
					if (got.err !== want.err)
						report("error_code", 64'(got.err), 64'(want.err));
					if (got.sat !== want.sat)
						report("saturated", 64'(got.sat), 64'(want.sat));
					if (got.mind !== want.mind)
						report("min_duration_seen", 64'(got.mind), 64'(want.mind));
					if (got.gcd !== want.gcd)
						report("duration_gcd", 64'(got.gcd), 64'(want.gcd));
				end
			end
			if (item_bus.valid && item_bus.ready) begin
				seen.op = rbm_pkg::op_t'(item_bus.operation);
				seen.dur = item_bus.duration;
				seen.distance = item_bus.distance;
				seen.tt = item_bus.travel_time;
				seen.vc = item_bus.vehicle_cost;
				if (fold_item(seen, want))
					expected_bounds.insert(expected_bounds.size(), want);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 3000000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic push(rbm_pkg::op_t op, logic [15:0] dur, logic [23:0] distance,
		logic [15:0] tt, logic [31:0] vc);
		route_item_t it;
		it = '{op: op, dur: dur, distance: distance, tt: tt, vc: vc};
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic push_random(int finish_pct);
		int r;
		logic [15:0] bases[8] = '{1, 2, 3, 4, 6, 8, 12, 60};
		route_item_t it;
		r = $urandom_range(0, 99);
		if (r < finish_pct)
			it.op = rbm_pkg::OP_FINISH;
		else
			it.op = rbm_pkg::op_t'($urandom_range(0, 2));
		r = $urandom_range(0, 99);
		if (r < 8)
			it.dur = '0;
		else if (r < 65)
			it.dur = bases[$urandom_range(0, 7)] * 16'($urandom_range(1, 40));
		else
			it.dur = 16'($urandom_range(0, 65535));
		it.distance = ($urandom_range(0, 1) != 0) ? 24'($urandom) : 24'($urandom_range(0, 500));
		r = $urandom_range(0, 99);
		if (r < 10)
			it.tt = '0;
		else if (r < 50)
			it.tt = 16'($urandom_range(1, 50));
		else
			it.tt = 16'($urandom_range(0, 65535));
		r = $urandom_range(0, 99);
		if (r < 8)
			it.vc = '0;
		else if (r < 16)
			it.vc = '1;
		else
			it.vc = $urandom;
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic set_register(rbm_pkg::reg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 4'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			rbm_pkg::REG_END_OF_DAY:        cfg_day_end = value[15:0];
			rbm_pkg::REG_COST_PER_DISTANCE: cfg_rate = value;
			rbm_pkg::REG_PER_VEHICLE_MODE:  cfg_per_vehicle = value[0];
			default:                        cfg_fleet = value[7:0];
		endcase
	endtask

	task automatic configure(logic [15:0] day_end, logic [31:0] rate, logic per_vehicle,
		logic [7:0] fleet);
		set_register(rbm_pkg::REG_END_OF_DAY, 32'(day_end));
		set_register(rbm_pkg::REG_COST_PER_DISTANCE, rate);
		set_register(rbm_pkg::REG_PER_VEHICLE_MODE, 32'(per_vehicle));
		set_register(rbm_pkg::REG_VEHICLE_COUNT, 32'(fleet));
	endtask

	// Sender holds until every outstanding result is in, then lets the
	// divider finish any trailing work before registers may change.
	task automatic drain();
		while (pending_items.size() != 0 || item_bus.valid || expected_bounds.size() != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	initial begin
		clear_bound_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under reset configuration.
		push(rbm_pkg::OP_FINISH, 16'd5, 24'd1, 16'd1, 32'd1);
		push(rbm_pkg::OP_DURATION, 16'd0, '1, '1, '1);
		push(rbm_pkg::OP_FINISH, '0, '0, '0, '0);
		push(rbm_pkg::OP_DURATION, 16'hffff, '0, '0, '0);
		push(rbm_pkg::OP_DURATION, 16'd1, '0, '0, '0);
		push(rbm_pkg::OP_PAIR, '0, 24'd100, 16'd0, '0);
		push(rbm_pkg::OP_PAIR, '0, 24'hffffff, 16'd1, '0);
		push(rbm_pkg::OP_PAIR, '0, 24'hfffffe, 16'd1, '0);
		push(rbm_pkg::OP_COST, '0, '0, '0, 32'hffffffff);
		push(rbm_pkg::OP_COST, '0, '0, '0, 32'd0);
		push(rbm_pkg::OP_FINISH, '0, '0, '0, '0);
		push(rbm_pkg::OP_DURATION, 16'hffff, '0, '0, '0);
		push(rbm_pkg::OP_PAIR, '0, 24'd7, 16'hffff, '0);
		push(rbm_pkg::OP_FINISH, '0, '0, '0, '0);
		drain();

		configure(16'd0, 32'hffffffff, 1'b1, 8'd0);
		push(rbm_pkg::OP_DURATION, 16'd5, '0, '0, '0);
		push(rbm_pkg::OP_FINISH, '0, '0, '0, '0);
		push(rbm_pkg::OP_DURATION, 16'd10, '0, '0, '0);
		push(rbm_pkg::OP_PAIR, '0, 24'd1, 16'hffff, '0);
		push(rbm_pkg::OP_COST, '0, '0, '0, 32'hffffffff);
		push(rbm_pkg::OP_COST, '0, '0, '0, 32'd3);
		push(rbm_pkg::OP_FINISH, '0, '0, '0, '0);
		// Cost sum runs past its 40-bit ceiling.
		for (int i = 0; i < 260; i++)
			push(rbm_pkg::OP_COST, '0, '0, '0, 32'hffffffff);
		push(rbm_pkg::OP_DURATION, 16'd1, '0, '0, '0);
		push(rbm_pkg::OP_FINISH, '0, '0, '0, '0);
		drain();

		// Random phases across register settings.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: configure(16'd1440, 32'd65536, 1'b0, 8'd1);
				1: configure(16'hffff, 32'hffffffff, 1'b0, 8'hff);
				2: configure(16'hffff, 32'd0, 1'b1, 8'hff);
				3: configure(16'd480, 32'h0002_8000, 1'b1, 8'd4);
				default: configure(16'($urandom), $urandom, 1'($urandom), 8'($urandom));
			endcase
			no_idle = (phase == 3);
			if (phase == 4) begin
				// Long stall on the result side while items keep coming.
				fork
					begin
						long_hold <= 1'b1;
						repeat (3000) @(posedge clk);
						long_hold <= 1'b0;
					end
				join_none
				for (int i = 0; i < 120; i++)
					push_random(35);
			end
			for (int i = 0; i < 158; i++)
				push_random(12);
			drain();
		end

		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

[files.f]
+incdir+src
src/rbm_pkg.sv
src/rbm_if.sv
src/rbm_regs.sv
src/rbm_ctrl.sv
src/rbm_datapath.sv
src/routing_big_m_bound_top.sv
src/rbm_checker.sv
verif/routing_big_m_bound_top_test.sv
